@@ hw/rtl/plwm_pkg.sv @@
// Shared types and constants for the per-second load window monitor.
package plwm_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int CHECK_SECONDS_DEF = 5;
  localparam int MATCH_NEEDED_DEF = 5;

  localparam int COUNT_W = 32;
  localparam int COST_W = 48;
  localparam int SUM_W = 52;
  localparam int HITS_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [3:0] WINDOW_MIN = 4'd1;
  localparam logic [3:0] WINDOW_MAX = 4'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  // Operation codes.
  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_QPS = 2'd1;
  localparam logic [1:0] OP_RT = 2'd2;
  localparam logic [1:0] OP_SUM = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_QPS_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RT_LIMIT = 1'd1;

  typedef struct packed {
    logic [1:0] operation;
    logic [31:0] now_sec;
    logic [31:0] cost_in;
    logic [3:0] window;
  } in_word_t;

  typedef struct packed {
    logic reached;
    logic [SUM_W-1:0] cost_sum;
    logic status;
  } out_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [COST_W-1:0] cost;
  } slot_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear_one;
    logic clear_all;
    logic set_second;
    logic acc_clear;
    logic rd;
    logic capture;
    logic eval;
    logic wr_record;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic adv;
    logic big;
    logic win_ok;
    logic [1:0] operation;
    logic [3:0] window;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/plwm_datapath.sv @@
// Datapath: slot memory, current second, limits, accumulators and output register.
module plwm_datapath import plwm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int MATCH_NEEDED = MATCH_NEEDED_DEF,
  localparam int PW = $clog2(SLOTS)
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  logic [PW-1:0] back,
  output sts_t sts,
  output logic [PW-1:0] gap,
  input  in_word_t in_word,
  output out_word_t out_word,
  output logic out_valid,
  input  logic out_stall,
  input  logic cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  in_word_t item;
  logic [31:0] index_second;
  logic [PW-1:0] cur;
  logic [31:0] qps_limit;
  logic [31:0] rt_limit;
  slot_t mem [SLOTS];
  logic [SLOTS-1:0] slot_valid;
  slot_t rdata;
  logic rvalid;
  logic [64:0] prod;
  logic [HITS_W-1:0] hits;
  logic [SUM_W-1:0] sum;

  logic [31:0] gap_full;
  logic [PW-1:0] nxt;
  logic [PW:0] rd_wide;
  logic [PW-1:0] rd_addr;
  logic [COUNT_W-1:0] rcount;
  logic [COST_W-1:0] rcost;
  logic hit;
  logic [COUNT_W-1:0] count_next;
  logic [COST_W:0] cost_wide;
  logic [COST_W-1:0] cost_next;
  logic is_check;

  // Time advance decisions.
  assign gap_full = item.now_sec - index_second;
  assign gap = gap_full[PW-1:0];
  assign sts.adv = item.now_sec > index_second;
  assign sts.big = gap_full >= 32'(SLOTS);
  assign sts.win_ok = (item.window >= WINDOW_MIN) && (item.window <= WINDOW_MAX);
  assign sts.operation = item.operation;
  assign sts.window = item.window;
  assign sts.out_free = !out_valid || !out_stall;

  // Ring arithmetic around the current slot.
  assign nxt = (cur == PW'(SLOTS - 1)) ? '0 : cur + 1'b1;
  assign rd_wide = ({1'b0, cur} >= {1'b0, back}) ? {1'b0, cur} - {1'b0, back}
                                                 : {1'b0, cur} + (PW+1)'(SLOTS) - {1'b0, back};
  assign rd_addr = rd_wide[PW-1:0];

  // A slot never written since its last clear reads as zero.
  assign rcount = rvalid ? rdata.count : '0;
  assign rcost = rvalid ? rdata.cost : '0;

  // QPS check: count above the limit. RT check: mean cost above the limit is tested as cost >= (limit + 1) * count.
  always_comb begin
    if (item.operation == OP_QPS) begin
      hit = rcount > qps_limit;
    end else begin
      hit = (rcount != '0) && ({17'd0, rcost} >= prod);
    end
  end

  // Saturating update of the current slot.
  assign count_next = (rcount == COUNT_MAX) ? COUNT_MAX : rcount + 1'b1;
  assign cost_wide = {1'b0, rcost} + {17'd0, item.cost_in};
  assign cost_next = cost_wide[COST_W] ? COST_MAX : cost_wide[COST_W-1:0];

  assign is_check = (item.operation == OP_QPS) || (item.operation == OP_RT);

  // Slot memory.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[cmd.wr_record ? cur : rd_addr];
    end
    if (cmd.wr_record) begin
      mem[cur] <= '{count: count_next, cost: cost_next};
    end
  end

  // Control state: second, pointer, valid bits, limits, output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      index_second <= '0;
      cur <= '0;
      slot_valid <= '0;
      qps_limit <= '1;
      rt_limit <= '1;
      out_valid <= 1'b0;
      rvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_QPS_LIMIT: qps_limit <= cfg_data;
          REG_RT_LIMIT: rt_limit <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.rd) begin
        rvalid <= slot_valid[cmd.wr_record ? cur : rd_addr];
      end
      if (cmd.clear_all) begin
        slot_valid <= '0;
      end else if (cmd.clear_one) begin
        slot_valid[nxt] <= 1'b0;
        cur <= nxt;
      end else if (cmd.wr_record) begin
        slot_valid[cur] <= 1'b1;
      end
      if (cmd.set_second) begin
        index_second <= item.now_sec;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item, accumulators and the result word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_word;
    end
    if (cmd.acc_clear) begin
      hits <= '0;
      sum <= '0;
    end else if (cmd.eval) begin
      hits <= hits + HITS_W'(hit);
      sum <= sum + SUM_W'(rcost);
    end
    if (cmd.capture) begin
      prod <= ({32'd0, rt_limit} + 64'd1) * {33'd0, rcount};
    end
    if (cmd.out_load) begin
      out_word.reached <= is_check && (hits >= HITS_W'(MATCH_NEEDED));
      out_word.cost_sum <= (item.operation == OP_SUM && sts.win_ok) ? sum : '0;
      out_word.status <= (item.operation == OP_SUM) && !sts.win_ok;
    end
  end

endmodule

@@ hw/rtl/plwm_ctrl.sv @@
// Controller: sequences time advance, slot walks and the result hand-off.
module plwm_ctrl import plwm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int CHECK_SECONDS = CHECK_SECONDS_DEF,
  localparam int PW = $clog2(SLOTS)
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  input  logic [PW-1:0] gap,
  output cmd_t cmd,
  output logic [PW-1:0] back
);

  typedef enum logic [2:0] {
    S_IDLE, S_ADV, S_CLR, S_OPS, S_RD, S_WAIT, S_EVAL, S_FIN
  } state_t;

  state_t state;
  logic [PW-1:0] cnt;
  logic [PW-1:0] lim;
  logic rec;

  assign in_stall = (state != S_IDLE);
  assign back = rec ? '0 : cnt;

  // Commands decoded from the state.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.load = in_valid;
      S_ADV: begin
        cmd.clear_all = sts.adv && sts.big;
        cmd.set_second = sts.adv && sts.big;
      end
      S_CLR: begin
        cmd.clear_one = 1'b1;
        cmd.set_second = (cnt == PW'(1));
      end
      S_OPS: cmd.acc_clear = 1'b1;
      S_RD: cmd.rd = 1'b1;
      S_WAIT: begin
        cmd.capture = 1'b1;
        cmd.rd = rec;
        cmd.wr_record = rec;
      end
      S_EVAL: cmd.eval = 1'b1;
      S_FIN: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      lim <= '0;
      rec <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_ADV;
        S_ADV: begin
          if (sts.adv && !sts.big) begin
            cnt <= gap;
            state <= S_CLR;
          end else begin
            state <= S_OPS;
          end
        end
        S_CLR: begin
          cnt <= cnt - 1'b1;
          if (cnt == PW'(1)) state <= S_OPS;
        end
        S_OPS: begin
          cnt <= PW'(1);
          lim <= (sts.operation == OP_SUM) ? PW'(sts.window) : PW'(CHECK_SECONDS);
          rec <= (sts.operation == OP_RECORD);
          if (sts.operation == OP_SUM && !sts.win_ok) begin
            state <= S_FIN;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_WAIT;
        S_WAIT: state <= rec ? S_FIN : S_EVAL;
        S_EVAL: begin
          if (cnt == lim) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt + 1'b1;
            state <= S_RD;
          end
        end
        S_FIN: if (sts.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_load_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_ADV) else $error("accepted word did not start work");
  a_out_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free) else $error("result loaded over a pending word");
  a_clear_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clear_all && cmd.clear_one)) else $error("full and single clear together");
  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL |-> cnt <= lim) else $error("slot walk overran its window");
`endif

endmodule

@@ hw/rtl/per_second_load_window_monitor.sv @@
// Top level of the per-second load window monitor.
//
// Input channel in_word (in_valid / in_stall): one word per request record,
// QPS check, RT check or cost sum, carrying the current second. Output
// channel out_word (out_valid / out_stall): exactly one result word per
// input word, in order. Configuration writes (cfg_valid / cfg_ready, ready
// always high) set qps_limit (index 0) and rt_limit (index 1).
// One word at a time is in work: in_stall stays high from acceptance until
// the result is loaded into the output register.
// Each word takes a time check and an operation setup, plus one clearing
// step per skipped second when time moves by less than SLOTS (a full ring
// clear needs no extra step), then a slot read and write for a record, a
// read, wait and evaluate step per slot for a check (CHECK_SECONDS slots)
// or cost sum (window slots), none for a bad window, then a result load
// and a return to idle before the next word is taken.
// The single-port slot memory and the slot walk set this sequence.
// Reset clears the limits to all ones, the second to zero and all slot
// valid bits at once, so no clearing pass is needed.
// When the receiver stalls, the result holds in the output register and the
// next word may be accepted; its result waits until the register frees.
module per_second_load_window_monitor import plwm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int CHECK_SECONDS = CHECK_SECONDS_DEF,
  parameter int MATCH_NEEDED = MATCH_NEEDED_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_word_t in_word,
  output logic out_valid,
  input  logic out_stall,
  output out_word_t out_word,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int PW = $clog2(SLOTS);

  cmd_t cmd;
  sts_t sts;
  logic [PW-1:0] gap;
  logic [PW-1:0] back;

  assign cfg_ready = 1'b1;

  plwm_ctrl #(.SLOTS(SLOTS), .CHECK_SECONDS(CHECK_SECONDS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .gap(gap), .cmd(cmd), .back(back)
  );

  plwm_datapath #(.SLOTS(SLOTS), .MATCH_NEEDED(MATCH_NEEDED)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .back(back), .sts(sts), .gap(gap),
    .in_word(in_word), .out_word(out_word), .out_valid(out_valid),
    .out_stall(out_stall), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

endmodule
